@@ hw/rtl/mtdm_pkg.sv @@
`default_nettype none

package mtdm_pkg;

	localparam int MAX_TAPS          = 4;
	localparam int DELAY_DEPTH_DEF   = 4096;
	localparam int TAP_COUNT_DEF     = 4;

	localparam int SAMPLE_W          = 16;
	localparam int GAIN_W            = 16;
	localparam int DELAY_W           = 12;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 16;
	localparam int PROD_W            = SAMPLE_W + GAIN_W;
	localparam int ACC_W             = PROD_W + 2;
	localparam int FRAC_W            = 15;
	localparam int TAP_IDX_W         = $clog2(MAX_TAPS);

	localparam int RECIP_SHIFT       = 24;
	localparam int RECIP_W           = 21;
	localparam int RPROD_W           = DELAY_W + RECIP_SHIFT;

	localparam logic REG_KIND_DELAY  = 1'b0;
	localparam logic REG_KIND_GAIN   = 1'b1;

	localparam logic signed [ACC_W-1:0]    RND_HALF = ACC_W'(1 << (FRAC_W - 1));
	localparam logic signed [SAMPLE_W-1:0] SMP_MAX  = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN  = 16'sh8000;

	typedef logic [TAP_IDX_W-1:0] tap_t;
	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE = 3'd0;
	localparam step_t STEP_RD0  = 3'd1;
	localparam step_t STEP_RD1  = 3'd2;
	localparam step_t STEP_RD2  = 3'd3;
	localparam step_t STEP_RD3  = 3'd4;
	localparam step_t STEP_MUL3 = 3'd5;
	localparam step_t STEP_FIN  = 3'd6;

	localparam tap_t TAP0 = TAP_IDX_W'(0);
	localparam tap_t TAP1 = TAP_IDX_W'(1);
	localparam tap_t TAP2 = TAP_IDX_W'(2);
	localparam tap_t TAP3 = TAP_IDX_W'(3);

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_WAIT_IN,
		JMP_WAIT_OUT
	} jmp_t;

	typedef struct packed {
		logic  accept;
		logic  rd_en;
		tap_t  rd_tap;
		logic  mul_en;
		tap_t  mul_tap;
		logic  acc_en;
		logic  fin;
		jmp_t  jmp;
		step_t next;
	} ucode_t;

	typedef struct packed {
		logic in_valid;
		logic out_busy;
	} seq_stat_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		w = '0;
		unique case (step)
			STEP_IDLE: begin
				w.accept = 1'b1;
				w.jmp    = JMP_WAIT_IN;
				w.next   = STEP_RD0;
			end
			STEP_RD0: begin
				w.rd_en  = 1'b1;
				w.rd_tap = TAP0;
				w.next   = STEP_RD1;
			end
			STEP_RD1: begin
				w.rd_en   = 1'b1;
				w.rd_tap  = TAP1;
				w.mul_en  = 1'b1;
				w.mul_tap = TAP0;
				w.next    = STEP_RD2;
			end
			STEP_RD2: begin
				w.rd_en   = 1'b1;
				w.rd_tap  = TAP2;
				w.mul_en  = 1'b1;
				w.mul_tap = TAP1;
				w.acc_en  = 1'b1;
				w.next    = STEP_RD3;
			end
			STEP_RD3: begin
				w.rd_en   = 1'b1;
				w.rd_tap  = TAP3;
				w.mul_en  = 1'b1;
				w.mul_tap = TAP2;
				w.acc_en  = 1'b1;
				w.next    = STEP_MUL3;
			end
			STEP_MUL3: begin
				w.mul_en  = 1'b1;
				w.mul_tap = TAP3;
				w.acc_en  = 1'b1;
				w.next    = STEP_FIN;
			end
			STEP_FIN: begin
				w.fin  = 1'b1;
				w.jmp  = JMP_WAIT_OUT;
				w.next = STEP_IDLE;
			end
			default: begin
				w.next = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/multitap_delay_mixer.sv @@
`default_nettype none

// Multitap delay mixer: each accepted sample is written into a circular delay store and one
// output sample is produced, the rounded and saturated sum over the taps of the sample stored
// that tap's delay ago times the tap's Q1.15 gain. A short microprogram walks the four tap
// slots through the store's single read port and one shared 16x16 multiplier, one tap per
// cycle, so a sample goes from acceptance to a loaded result in steps: one to store the
// sample, four tap reads overlapped with the multiply and accumulate, one to drain the last
// product and one to round and saturate. A finished result waits in the output register while
// the next sample is taken. Entries of the store that were never written read as zero without
// any clearing pass after reset. A delay written through the configuration port is reduced
// modulo the store depth in the cycle after the write.

module multitap_delay_mixer
	import mtdm_pkg::*;
#(
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
	parameter int TAP_COUNT   = TAP_COUNT_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [SAMPLE_W-1:0]   sample_in,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [SAMPLE_W-1:0]        sample_out,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_W-1:0]         cfg_idx,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam logic [AW:0]          DEPTH_EXT = (AW + 1)'(DELAY_DEPTH);
	localparam logic [AW-1:0]        WP_LAST   = AW'(DELAY_DEPTH - 1);
	localparam logic [DELAY_W-1:0]   DEPTH_LO  = DELAY_W'(DELAY_DEPTH % (1 << DELAY_W));
	localparam logic [RECIP_W-1:0]   RECIP     =
		RECIP_W'(((longint'(1) << RECIP_SHIFT) + DELAY_DEPTH - 1) / DELAY_DEPTH);

	ucode_t    ctrl;
	logic      go;
	seq_stat_t stat;

	logic accept_go;
	logic fin_go;

	logic [AW-1:0]              dly_q  [TAP_COUNT];
	logic signed [GAIN_W-1:0]   gain_q [TAP_COUNT];
	logic [AW-1:0]              dly_ext  [MAX_TAPS];
	logic signed [GAIN_W-1:0]   gain_ext [MAX_TAPS];

	logic                   cfg_valid_s1;
	tap_t                   cfg_tap_s1;
	logic [DELAY_W-1:0]     cfg_dly_s1;
	logic [DELAY_W-1:0]     cfg_quo_s1;
	logic [RPROD_W-1:0]     cfg_rprod;
	logic [DELAY_W-1:0]     cfg_qd;
	logic [DELAY_W-1:0]     cfg_rem;

	logic [AW-1:0]              wp_q;
	logic                       wrapped_q;
	logic [AW:0]                rd_diff;
	logic [AW-1:0]              rd_addr;
	logic                       rd_hit;
	logic                       rd_valid_q;
	logic [SAMPLE_W-1:0]        rd_data;
	logic signed [SAMPLE_W-1:0] mul_smp;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    fin_sum;
	logic signed [ACC_W-FRAC_W-1:0] fin_shf;
	logic signed [SAMPLE_W-1:0] fin_res;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;

	assign stat.in_valid = in_valid;
	assign stat.out_busy = out_valid_q && out_stall;

	mtdm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl),
		.go     (go)
	);

	assign in_stall  = !ctrl.accept;
	assign accept_go = ctrl.accept && go;
	assign fin_go    = ctrl.fin && go;

	// Delay reduction: quotient by reciprocal multiply, remainder in the next cycle.
	assign cfg_rprod = RPROD_W'(cfg_data[DELAY_W-1:0]) * RPROD_W'(RECIP);
	assign cfg_qd    = cfg_quo_s1 * DEPTH_LO;
	assign cfg_rem   = cfg_dly_s1 - cfg_qd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid_s1 <= 1'b0;
		end else begin
			cfg_valid_s1 <= cfg_we && (cfg_idx[0] == REG_KIND_DELAY);
		end
	end

	always_ff @(posedge clk) begin
		cfg_tap_s1 <= cfg_idx[CFG_IDX_W-1:1];
		cfg_dly_s1 <= cfg_data[DELAY_W-1:0];
		cfg_quo_s1 <= cfg_rprod[RPROD_W-1:RECIP_SHIFT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TAP_COUNT; t++) begin
				dly_q[t]  <= '0;
				gain_q[t] <= '0;
			end
		end else begin
			for (int t = 0; t < TAP_COUNT; t++) begin
				if (cfg_valid_s1 && cfg_tap_s1 == TAP_IDX_W'(t)) begin
					dly_q[t] <= AW'(cfg_rem);
				end
				if (cfg_we && cfg_idx[0] == REG_KIND_GAIN &&
				    cfg_idx[CFG_IDX_W-1:1] == TAP_IDX_W'(t)) begin
					gain_q[t] <= $signed(cfg_data[GAIN_W-1:0]);
				end
			end
		end
	end

	for (genvar t = 0; t < MAX_TAPS; t++) begin : g_tap
		if (t < TAP_COUNT) begin : g_used
			assign dly_ext[t]  = dly_q[t];
			assign gain_ext[t] = gain_q[t];
		end else begin : g_unused
			assign dly_ext[t]  = '0;
			assign gain_ext[t] = '0;
		end
	end

	// Read address: write pointer minus delay, wrapped round the store.
	always_comb begin
		rd_diff = {1'b0, wp_q} - {1'b0, dly_ext[ctrl.rd_tap]};
		if (rd_diff[AW]) begin
			rd_addr = AW'(rd_diff + DEPTH_EXT);
		end else begin
			rd_addr = rd_diff[AW-1:0];
		end
		rd_hit = wrapped_q || (rd_addr <= wp_q);
	end

	mtdm_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DELAY_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (accept_go),
		.wr_addr (wp_q),
		.wr_data (sample_in),
		.rd_en   (ctrl.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			wrapped_q  <= 1'b0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctrl.rd_en) begin
				rd_valid_q <= rd_hit;
			end
			if (fin_go) begin
				if (wp_q == WP_LAST) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + AW'(1);
				end
			end
		end
	end

	assign mul_smp = rd_valid_q ? $signed(rd_data) : '0;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= mul_smp * gain_ext[ctrl.mul_tap];
		end
		if (accept_go) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	always_comb begin
		fin_sum = acc_q + ACC_W'(prod_q) + RND_HALF;
		fin_shf = fin_sum[ACC_W-1:FRAC_W];
		if (fin_shf > (ACC_W - FRAC_W)'(SMP_MAX)) begin
			fin_res = SMP_MAX;
		end else if (fin_shf < (ACC_W - FRAC_W)'(SMP_MIN)) begin
			fin_res = SMP_MIN;
		end else begin
			fin_res = fin_shf[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			sample_out_q <= fin_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	a_wp_moves_at_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q != $past(wp_q)) |-> $past(fin_go))
		else $error("write pointer moved outside the final step");

	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept_go && ctrl.rd_en))
		else $error("delay store read and written in the same cycle");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fin_go))
		else $error("output beat raised without a finished sum");

endmodule

`default_nettype wire

@@ hw/rtl/mtdm_ram.sv @@
`default_nettype none

module mtdm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/mtdm_seq.sv @@
`default_nettype none

module mtdm_seq
	import mtdm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire seq_stat_t stat,
	output ucode_t         ctrl,
	output logic           go
);

	step_t step_q;
	logic  hold;

	assign ctrl = ucode_rom(step_q);

	always_comb begin
		unique case (ctrl.jmp)
			JMP_NEXT:     hold = 1'b0;
			JMP_WAIT_IN:  hold = !stat.in_valid;
			JMP_WAIT_OUT: hold = stat.out_busy;
			default:      hold = 1'b0;
		endcase
	end

	assign go = !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else if (go) begin
			step_q <= ctrl.next;
		end
	end

endmodule

`default_nettype wire

@@ test/multitap_delay_mixer_tb.sv @@
`default_nettype none

module multitap_delay_mixer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mtdm_pkg::*;

	localparam int STORE_DEPTH   = DELAY_DEPTH_DEF;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 150;
	localparam int PHASE_BEATS   = 50;
	localparam int PHASE_COUNT   = 8;

	class mix_tracker;
		logic signed [SAMPLE_W-1:0] history [STORE_DEPTH];
		logic [DELAY_W-1:0]         wr_ptr;
		logic [DELAY_W-1:0]         tap_delay [MAX_TAPS];
		logic signed [GAIN_W-1:0]   tap_gain [MAX_TAPS];
		logic signed [SAMPLE_W-1:0] expected_mix [$];
		int                         mismatches;
		int                         fed;
		int                         checked;

		function new();
			foreach (history[i])
				history[i] = '0;
			foreach (tap_delay[i]) begin
				tap_delay[i] = '0;
				tap_gain[i]  = '0;
			end
			wr_ptr     = '0;
			mismatches = 0;
			fed        = 0;
			checked    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			int t;
			t = int'(idx >> 1);
			if (idx[0] == REG_KIND_DELAY)
				tap_delay[t] = data[DELAY_W-1:0];
			else
				tap_gain[t] = data;
		endfunction

		function int pending();
			return expected_mix.size();
		endfunction

		function void note_sample(logic signed [SAMPLE_W-1:0] s);
			longint                acc;
			longint                rounded;
			logic [DELAY_W-1:0]    rd;
			history[wr_ptr] = s;
			acc = 0;
			for (int t = 0; t < TAP_COUNT_DEF; t++) begin
				rd  = wr_ptr - tap_delay[t];
				acc += longint'(history[rd]) * longint'(tap_gain[t]);
			end
			rounded = (acc + 64'sd16384) >>> FRAC_W;
			if (rounded > longint'(SMP_MAX))
				rounded = longint'(SMP_MAX);
			if (rounded < longint'(SMP_MIN))
				rounded = longint'(SMP_MIN);
			expected_mix.push_back(SAMPLE_W'(rounded));
			wr_ptr = wr_ptr + 1'b1;
			fed++;
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 20)
				$display("MISMATCH: %s", msg);
		endtask

		task check_mix(logic signed [SAMPLE_W-1:0] got);
			logic signed [SAMPLE_W-1:0] want;
			if (expected_mix.size() == 0) begin
				report_mismatch($sformatf("sample_out %0d with no sample waiting", got));
			end else begin
				want = expected_mix.pop_front();
				checked++;
				if (got !== want)
					report_mismatch($sformatf("mix %0d: sample_out %0d, expected %0d",
						checked, got, want));
			end
		endtask
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_idx = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;

	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int hold_len       = 0;
	int settings_used  = 0;

	mix_tracker sb = new();

	multitap_delay_mixer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_sample(sample_in);
			if (out_valid && !out_stall)
				sb.check_mix(sample_out);
		end
	end

	// The receiver stalls at random, or for a whole stretch when one is requested.
	initial begin
		int held;
		held = 0;
		forever begin
			@(negedge clk);
			if (hold_len != 0) begin
				held     = hold_len;
				hold_len = 0;
			end
			if (held > 0) begin
				out_stall <= 1'b1;
				held--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d mixes outstanding.", sb.pending());
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain(input int extra);
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(input tap_t t, input logic kind, input logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= {t, kind};
		cfg_data <= data;
		sb.set_reg({t, kind}, data);
		@(negedge clk);
	endtask

	task automatic program_taps(input logic [DELAY_W-1:0] d [MAX_TAPS],
			input logic [GAIN_W-1:0] g [MAX_TAPS]);
		drain(SETTLE_CYCLES);
		for (int t = 0; t < MAX_TAPS; t++) begin
			write_reg(tap_t'(t), REG_KIND_DELAY, CFG_DATA_W'(d[t]));
			write_reg(tap_t'(t), REG_KIND_GAIN, g[t]);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
		settings_used++;
	endtask

	task automatic random_taps();
		logic [DELAY_W-1:0] d [MAX_TAPS];
		logic [GAIN_W-1:0]  g [MAX_TAPS];
		int                 r;
		for (int t = 0; t < MAX_TAPS; t++) begin
			r = $urandom_range(9);
			if (r < 5)
				d[t] = DELAY_W'($urandom_range(40));
			else if (r == 5)
				d[t] = '0;
			else if (r == 6)
				d[t] = '1;
			else
				d[t] = DELAY_W'($urandom_range(STORE_DEPTH - 1));
			r = $urandom_range(9);
			if (r < 2)
				g[t] = '0;
			else if (r == 2)
				g[t] = SMP_MIN;
			else if (r == 3)
				g[t] = SMP_MAX;
			else
				g[t] = GAIN_W'($urandom);
		end
		program_taps(d, g);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return SMP_MAX;
		if (r == 1)
			return SMP_MIN;
		if (r == 2)
			return SAMPLE_W'($urandom_range(64)) - 16'sd32;
		return SAMPLE_W'($urandom);
	endfunction

	initial begin
		logic [DELAY_W-1:0] d [MAX_TAPS];
		logic [GAIN_W-1:0]  g [MAX_TAPS];

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// With every gain at reset the mix is silent, but the samples still land in the store.
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);

		// Current sample, one back at full negative gain, the oldest entry, and an unused tap.
		d = '{12'd0, 12'd1, 12'd4095, 12'd2};
		g = '{16'h7fff, 16'h8000, 16'h4000, 16'h0000};
		program_taps(d, g);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		send_sample(16'sd0);
		send_sample(SMP_MIN);
		send_sample(SMP_MIN);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sh5555);
		send_sample(16'shaaaa);

		// Four taps in phase drive the sum past both rails.
		d = '{12'd0, 12'd1, 12'd2, 12'd3};
		g = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
		program_taps(d, g);
		repeat (4) send_sample(SMP_MAX);
		repeat (4) send_sample(SMP_MIN);

		// A gain of one LSB puts exact halves on the rounding boundary.
		d = '{12'd0, 12'd4095, 12'd4095, 12'd4095};
		g = '{16'h0001, 16'h0000, 16'h0000, 16'h0000};
		program_taps(d, g);
		send_sample(16'sd16384);
		send_sample(-16'sd16384);
		send_sample(16'sd16383);
		send_sample(-16'sd16385);

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			random_taps();
			case (phase % 4)
				0: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct   = 50;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct   = 0;
					recv_stall_pct = 50;
				end
				default: begin
					send_gap_pct   = 7;
					recv_stall_pct = 7;
				end
			endcase
			if (phase == 2) begin
				send_gap_pct = 0;
				hold_len     = HOLD_CYCLES;
			end
			for (int i = 0; i < PHASE_BEATS; i++) begin
				if (phase == 5 && i == PHASE_BEATS / 2)
					drain(0);
				send_sample(random_sample());
			end
		end

		drain(SETTLE_CYCLES);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d mixes never arrived", sb.pending()));

		$display("Fed %0d samples and checked %0d mixes across %0d tap settings,",
			sb.fed, sb.checked, settings_used);
		$display("with rail, rounding and long-hold cases under four idling mixes.");
		if (sb.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
